FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for concurrent checks clocked on a rising edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Types, constants and helper functions of the temperature blend pipeline.
// ----------------------------------------------------------------------------
package stb_pkg;

   // Configuration register indexes
   localparam logic CSR_LOWER = 1'b0;
   localparam logic CSR_UPPER = 1'b1;

   // Reset values of the thresholds
   localparam logic signed [8:0] LOWER_RESET = 9'sd60;
   localparam logic signed [8:0] UPPER_RESET = 9'sd100;

   // Sensor range, one bit wider than a temperature
   localparam logic signed [9:0] TEMP_MIN = -10'sd40;
   localparam logic signed [9:0] TEMP_MAX = 10'sd140;

   typedef enum logic [1:0] {
      SEL_SYS,
      SEL_NTC,
      SEL_BLEND
   } sel_type;

   // Fields that ride along the pipeline with each item
   typedef struct packed {
      sel_type           sel;
      logic signed [8:0] ntc;
      logic signed [8:0] sys;
      logic              neg;
   } side_type;

   // Restoring divider state: partial remainder, dividend bits still
   // to shift in, quotient bits so far
   typedef struct packed {
      logic [8:0] rem;
      logic [8:0] dl;
      logic [8:0] q;
   } div_type;

   // Three restoring division steps
   function automatic div_type div_step3(input div_type d, input logic [8:0] span);
      div_type    r;
      logic [9:0] t;
      r = d;
      for (int i = 0; i < 3; i++) begin
         t    = {r.rem, r.dl[8]};
         r.dl = {r.dl[7:0], 1'b0};
         if (t >= {1'b0, span}) begin
            t   = t - {1'b0, span};
            r.q = {r.q[7:0], 1'b1};
         end else begin
            r.q = {r.q[7:0], 1'b0};
         end
         r.rem = t[8:0];
      end
      return r;
   endfunction

   // Saturate to the sensor range
   function automatic logic signed [8:0] clamp_temp(input logic signed [9:0] v);
      if (v < TEMP_MIN) begin
         return TEMP_MIN[8:0];
      end else if (v > TEMP_MAX) begin
         return TEMP_MAX[8:0];
      end
      return v[8:0];
   endfunction

endpackage

FILE: hw/rtl/sensor_temperature_blend.sv
// ----------------------------------------------------------------------------
// sensor_temperature_blend
// Blends an NTC temperature with a system temperature over a threshold band.
// ----------------------------------------------------------------------------
// Each transfer on the req_ side carries an NTC temperature, a system
// temperature and an NTC error flag; one transfer on the rsp_ side returns the
// blended temperature. Below or at the lower threshold, on an NTC error, or
// when the band is empty (upper not above lower) the system temperature is
// returned; at or above the upper threshold the NTC temperature; in between
// (ntc*(ntc-low) + sys*(up-ntc)) / (up-low), rounded half away from zero, and
// every result is saturated to -40..140. The block is a seven-stage pipeline:
// decode and band tests, two multipliers, sum with rounding offset, a
// restoring divider spread over three stages at three quotient bits each, and
// the output register. It accepts one transfer per cycle while the output side
// does not stall. Each stage holds its item while the stage behind it cannot
// load, so bubbles collapse and a stall drops or repeats nothing. Thresholds
// reset to 60 and 100 and are written through csr_we/csr_addr/csr_wdata; the
// user must write them only while the pipeline is empty, which the block
// itself does not enforce.
module sensor_temperature_blend (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [8:0] ntc_temp, [17:9] sys_temp, zero fill
   input  logic        req_tuser,   // ntc_error
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [8:0] blended_temp, zero fill
   // Configuration write port
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [8:0]  csr_wdata
);

   localparam int NSTG = 7;

   // Threshold registers
   logic signed [8:0] lower_ff, upper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= stb_pkg::LOWER_RESET;
         upper_ff <= stb_pkg::UPPER_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            stb_pkg::CSR_LOWER: lower_ff <= csr_wdata;
            stb_pkg::CSR_UPPER: upper_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage valid bits and per-stage advance enables. A stage loads when it
   // is empty or when the stage behind it loads in the same cycle.
   logic [NSTG:1] valid_ff, valid_in;
   logic [NSTG:1] en;

   always_comb begin
      en[NSTG] = !valid_ff[NSTG] || rsp_tready;
      for (int k = NSTG - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_comb begin
      valid_in[1] = en[1] ? req_tvalid : valid_ff[1];
      for (int k = 2; k <= NSTG; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en[1];
   assign rsp_tvalid = valid_ff[NSTG];

   // Pipeline payload
   stb_pkg::side_type side_ff [1:6];
   logic [8:0]        span_ff [1:6];
   logic [8:0]        wa1_ff, wb1_ff;
   logic signed [18:0] pa2_ff, pb2_ff;
   logic [18:0]       mag3_ff;
   stb_pkg::div_type  div_ff  [4:6];
   logic signed [8:0] res_ff;

   // Stage 1: band tests and weights
   logic signed [8:0] ntc_in, sys_in;
   logic signed [9:0] span_w, lo_diff, up_diff;
   stb_pkg::side_type side1_in;

   always_comb begin
      ntc_in  = req_tdata[8:0];
      sys_in  = req_tdata[17:9];
      span_w  = {upper_ff[8], upper_ff} - {lower_ff[8], lower_ff};
      lo_diff = {ntc_in[8], ntc_in} - {lower_ff[8], lower_ff};
      up_diff = {upper_ff[8], upper_ff} - {ntc_in[8], ntc_in};
      side1_in.ntc = ntc_in;
      side1_in.sys = sys_in;
      side1_in.neg = 1'b0;
      // Empty band, low NTC or a faulty sensor fall back to the system value
      if (span_w <= 0 || lo_diff <= 0 || req_tuser) begin
         side1_in.sel = stb_pkg::SEL_SYS;
      end else if (up_diff <= 0) begin
         side1_in.sel = stb_pkg::SEL_NTC;
      end else begin
         side1_in.sel = stb_pkg::SEL_BLEND;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         side_ff[1] <= side1_in;
         span_ff[1] <= span_w[8:0];
         wa1_ff     <= lo_diff[8:0];
         wb1_ff     <= up_diff[8:0];
      end
   end

   // Stage 2: weight products
   logic signed [18:0] pa_in, pb_in;

   always_comb begin
      pa_in = $signed({{10{side_ff[1].ntc[8]}}, side_ff[1].ntc}) * $signed({10'b0, wa1_ff});
      pb_in = $signed({{10{side_ff[1].sys[8]}}, side_ff[1].sys}) * $signed({10'b0, wb1_ff});
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         side_ff[2] <= side_ff[1];
         span_ff[2] <= span_ff[1];
         pa2_ff     <= pa_in;
         pb2_ff     <= pb_in;
      end
   end

   // Stage 3: numerator, its magnitude plus half the span for rounding
   logic signed [18:0] num_in;
   logic [18:0]        mag_in;
   stb_pkg::side_type  side3_in;

   always_comb begin
      num_in   = pa2_ff + pb2_ff;
      side3_in = side_ff[2];
      side3_in.neg = num_in[18];
      mag_in   = (num_in[18] ? 19'(-num_in) : 19'(num_in)) + {10'b0, 1'b0, span_ff[2][8:1]};
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         side_ff[3] <= side3_in;
         span_ff[3] <= span_ff[2];
         mag3_ff    <= mag_in;
      end
   end

   // Stages 4 to 6: restoring divider, three quotient bits per stage.
   // The quotient stays below 512, so the top dividend bits start as the
   // partial remainder.
   stb_pkg::div_type div_init;

   always_comb begin
      div_init.rem = mag3_ff[17:9];
      div_init.dl  = mag3_ff[8:0];
      div_init.q   = '0;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         side_ff[4] <= side_ff[3];
         span_ff[4] <= span_ff[3];
         div_ff[4]  <= stb_pkg::div_step3(div_init, span_ff[3]);
      end
      for (int k = 5; k <= 6; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
            span_ff[k] <= span_ff[k-1];
            div_ff[k]  <= stb_pkg::div_step3(div_ff[k-1], span_ff[k-1]);
         end
      end
   end

   // Stage 7: apply sign, pick the source, saturate
   logic signed [9:0] quo_s;
   logic signed [8:0] res_in;

   always_comb begin
      quo_s = side_ff[6].neg ? -$signed({1'b0, div_ff[6].q}) : $signed({1'b0, div_ff[6].q});
      case (side_ff[6].sel)
         stb_pkg::SEL_NTC:   res_in = stb_pkg::clamp_temp({side_ff[6].ntc[8], side_ff[6].ntc});
         stb_pkg::SEL_BLEND: res_in = stb_pkg::clamp_temp(quo_s);
         default:            res_in = stb_pkg::clamp_temp({side_ff[6].sys[8], side_ff[6].sys});
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tdata = {7'b0, res_ff};

   // Checks
`include "assert_macros.svh"

   // A blended item always has a non-empty band
   `ASSERT_IMPLY(a_blend_span, clock, reset,
      valid_ff[3] && side_ff[3].sel == stb_pkg::SEL_BLEND, span_ff[3] != 9'd0)
   // Divider precondition: the quotient fits nine bits
   `ASSERT_IMPLY(a_div_range, clock, reset,
      valid_ff[3] && side_ff[3].sel == stb_pkg::SEL_BLEND,
      !mag3_ff[18] && (mag3_ff[17:9] < span_ff[3]))
   // Final remainder is reduced below the divisor
   `ASSERT_IMPLY(a_div_rem, clock, reset,
      valid_ff[6] && side_ff[6].sel == stb_pkg::SEL_BLEND, div_ff[6].rem < span_ff[6])
   // An empty output stage never blocks the input side
   `ASSERT_IMPLY(a_no_block, clock, reset, !valid_ff[NSTG], req_tready)

endmodule

FILE: sim/sensor_temperature_blend_test.sv
// ----------------------------------------------------------------------------
// sensor_temperature_blend_test
// Self-checking bench for the NTC / system temperature blend pipeline.
// ----------------------------------------------------------------------------
// A scoreboard predicts each blended temperature from the thresholds it tracks
// and the fields of every accepted request. Each response is checked in order
// against those predictions. The run starts with directed samples at the reset
// thresholds: band edges, rounding halves, error priority and saturation.
// It then walks through a series of threshold settings, including empty bands
// and the extremes of the register range, with random samples under changing
// backpressure. One long response stall fills the pipeline.
// ----------------------------------------------------------------------------
module sensor_temperature_blend_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PHASES      = 12;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int HOLD_CYCLES     = 300;   // long response stall, fills the pipeline
   localparam int STALL_LIMIT     = 2000;  // cycles without any transfer before giving up
   localparam int FLUSH_CYCLES    = 20;    // pipeline is seven deep, leave room for strays
   localparam int HOLD_PHASE      = 8;

   // Threshold settings of the first ten random phases; the last two phases draw theirs at random
   localparam int LOWER_SET[10] = '{-40, 140, 50, 0, -40, 139, 20, -256, 255, 60};
   localparam int UPPER_SET[10] = '{140, -40, 50, 1, -39, 140, 83, 255, -256, 100};

   // ------------------------------------------------------------------------
   // Scoreboard: tracks the thresholds and the queue of predicted temperatures
   // ------------------------------------------------------------------------
   class blend_scoreboard;
      logic signed [8:0] lower_thr;
      logic signed [8:0] upper_thr;
      logic [8:0]        expected_temps[$];
      int                errors;

      function new();
         lower_thr = stb_pkg::LOWER_RESET;
         upper_thr = stb_pkg::UPPER_RESET;
         errors    = 0;
      endfunction

      function void set_threshold(logic addr, logic [8:0] value);
         if (addr == stb_pkg::CSR_LOWER) begin
            lower_thr = value;
         end else begin
            upper_thr = value;
         end
      endfunction

      function logic [8:0] blend_temp(logic signed [8:0] ntc, logic signed [8:0] sys,
                                      logic err);
         int n, s, lo, up, span, num, res;
         n    = ntc;
         s    = sys;
         lo   = lower_thr;
         up   = upper_thr;
         span = up - lo;
         if (span <= 0 || n <= lo || err) begin
            res = s;
         end else if (n >= up) begin
            res = n;
         end else begin
            num = n * (n - lo) + s * (up - n);
            // round half away from zero; integer division truncates toward zero
            if (num >= 0) begin
               res = (num + span / 2) / span;
            end else begin
               res = (num - span / 2) / span;
            end
         end
         if (res < stb_pkg::TEMP_MIN) begin
            res = stb_pkg::TEMP_MIN;
         end else if (res > stb_pkg::TEMP_MAX) begin
            res = stb_pkg::TEMP_MAX;
         end
         return res[8:0];
      endfunction

      function void note_sample(logic [8:0] ntc, logic [8:0] sys, logic err);
         expected_temps.push_back(blend_temp(ntc, sys, err));
      endfunction

      function void check_temp(logic [8:0] actual);
         logic [8:0] want;
         if (expected_temps.size() == 0) begin
            $display("%0t: blended_temp with nothing pending, expected none, actual %0d",
                     $time, $signed(actual));
            errors++;
            return;
         end
         want = expected_temps.pop_front();
         if (actual !== want) begin
            $display("%0t: blended_temp mismatch, expected %0d, actual %0d",
                     $time, $signed(want), $signed(actual));
            errors++;
         end
      endfunction

      function int pending();
         return expected_temps.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Block signals, the inputs all known from time zero
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;    // [8:0] ntc_temp, [17:9] sys_temp, zero fill
   logic        req_tuser  = 1'b0;  // ntc_error
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [8:0] blended_temp, zero fill
   logic        csr_we     = 1'b0;
   logic        csr_addr   = stb_pkg::CSR_LOWER;
   logic [8:0]  csr_wdata  = '0;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int stall_requests = 0;   // bumped by the stimulus, one long stall each
   int stall_served   = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   blend_scoreboard sb = new();

   sensor_temperature_blend dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Response side: random backpressure, plus a long hold-off on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_requests != stall_served) begin
         // start a long hold-off, counted down here
         stall_served <= stall_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each response transfer and watch for a hung pipeline
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_temp(rsp_tdata[8:0]);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus tasks
   // ------------------------------------------------------------------------

   // Offer one sample, hold it until the transfer, then maybe idle a while
   task automatic send_item(int ntc, int sys, bit err);
      logic [8:0] n9, s9;
      n9 = ntc[8:0];
      s9 = sys[8:0];
      req_tdata  <= {6'b0, s9, n9};
      req_tuser  <= err;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_sample(n9, s9, err);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Random sample; about half land inside the band so the divider gets work
   task automatic send_random_item();
      int lo, up, ntc, sys, roll;
      lo   = sb.lower_thr;
      up   = sb.upper_thr;
      roll = $urandom_range(99);
      if (roll < 5) begin
         ntc = int'($urandom_range(511)) - 256;
      end else if (roll < 55 && up > lo) begin
         ntc = lo + int'($urandom_range(up - lo));
      end else begin
         ntc = int'($urandom_range(180)) - 40;
      end
      if ($urandom_range(99) < 5) begin
         sys = int'($urandom_range(511)) - 256;
      end else begin
         sys = int'($urandom_range(180)) - 40;
      end
      send_item(ntc, sys, $urandom_range(99) < 15);
   endtask

   // Drop valid and wait for every predicted temperature to come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Write both thresholds on back-to-back edges; the pipeline must be empty
   task automatic apply_thresholds(int lo, int up);
      csr_we    <= 1'b1;
      csr_addr  <= stb_pkg::CSR_LOWER;
      csr_wdata <= lo[8:0];
      @(posedge clock);
      sb.set_threshold(stb_pkg::CSR_LOWER, lo[8:0]);
      csr_addr  <= stb_pkg::CSR_UPPER;
      csr_wdata <= up[8:0];
      @(posedge clock);
      sb.set_threshold(stb_pkg::CSR_UPPER, up[8:0]);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int lo, up;
      repeat (8) @(posedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 13;
      recv_idle_pct <= 88;
      @(posedge clock);

      // Directed samples at the reset thresholds (band 60..100)
      send_item(-40, 25, 0);     // coldest NTC, below the band
      send_item(140, -40, 0);    // hottest NTC, above the band
      send_item(60, 140, 0);     // on the lower threshold: system value
      send_item(61, -40, 0);     // just inside the band
      send_item(99, 140, 0);     // just below the upper threshold
      send_item(100, -40, 0);    // on the upper threshold: NTC value
      send_item(70, 0, 0);       // positive half, rounds up to 18
      send_item(70, -40, 0);     // negative half, rounds down to -13
      send_item(80, 80, 1);      // error inside the band
      send_item(120, 30, 1);     // error wins over the upper test
      send_item(-40, -40, 1);
      send_item(140, 140, 0);
      send_item(255, 0, 0);      // out of range NTC above the band saturates high
      send_item(-256, 100, 0);   // out of range NTC below the band
      send_item(61, -256, 0);    // blend that saturates low
      send_item(99, 255, 0);     // blend with an out of range system value, stays in range
      send_item(0, -1, 0);
      send_item(-1, 1, 1);
      send_item(85, 170, 0);
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < 10) begin
            lo = LOWER_SET[phase];
            up = UPPER_SET[phase];
         end else begin
            lo = int'($urandom_range(180)) - 40;
            up = int'($urandom_range(180)) - 40;
         end
         // sender fast and receiver slow, then the reverse, then full rate
         if (phase < 4) begin
            send_idle_pct <= 13;
            recv_idle_pct <= 88;
         end else if (phase < 8) begin
            send_idle_pct <= 88;
            recv_idle_pct <= 13;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         apply_thresholds(lo, up);
         if (phase == HOLD_PHASE) begin
            stall_requests <= stall_requests + 1;
         end
         repeat (ITEMS_PER_PHASE) send_random_item();
         drain();
      end

      // Let any stray response show up before the verdict
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
